>>> design/bphq_pkg.sv
package bphq_pkg;

	localparam int PINS    = 32;
	localparam int PIN_W   = $clog2(PINS);
	localparam int STAMP_W = 32;
	localparam int HOLD_W  = 16;
	localparam int VAL_W   = 8;
	localparam int SLOT_W  = 8;
	localparam int KIND_W  = 3;

	// Per-pin qualifier state
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_SET      = 3'd1,
		ST_ACTIVE   = 3'd2,
		ST_RELEASED = 3'd3,
		ST_TS_OFF   = 3'd4,
		ST_TS_ON    = 3'd5
	} pin_state_t;

	// Button modes
	typedef enum logic [KIND_W-1:0] {
		KIND_EDGE        = 3'd0,
		KIND_FILTERED    = 3'd1,
		KIND_TWO_STATE   = 3'd2,
		KIND_PRESS_HOLD  = 3'd3,
		KIND_REPEAT_HOLD = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PIN_W-1:0]   pin;
		logic               level;
		logic               active_low;
		logic [VAL_W-1:0]   value;
		logic [VAL_W-1:0]   value_alt;
		logic [SLOT_W-1:0]  slot;
		logic [SLOT_W-1:0]  slot_alt;
		logic [HOLD_W-1:0]  hold_time;
		logic [STAMP_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] write_slot;
		logic              write_enable;
		logic              changed;
		logic [VAL_W-1:0]  result_value;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [PIN_W-1:0] addr;
		pin_state_t       data;
	} st_wr_t;

	typedef struct packed {
		logic               en;
		logic [PIN_W-1:0]   addr;
		logic [STAMP_W-1:0] data;
	} ts_wr_t;

endpackage

>>> design/bphq_state_mem.sv
module bphq_state_mem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [bphq_pkg::PIN_W-1:0]     rd_addr,
	output bphq_pkg::pin_state_t           rd_data,
	input  bphq_pkg::st_wr_t               wr
);

	bphq_pkg::pin_state_t mem [bphq_pkg::PINS];
	logic [bphq_pkg::PINS-1:0] valid_q;
	bphq_pkg::pin_state_t rd_q;

	// Write port and registered read; an entry never written reads as idle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem[rd_addr] : bphq_pkg::ST_IDLE;
		end
	end

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_q;

	a_written_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> valid_q[$past(wr.addr)])
		else $error("state entry not marked valid after write");

	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $countones($past(valid_q)))
		else $error("state valid bits dropped without reset");

endmodule

>>> design/bphq_stamp_mem.sv
module bphq_stamp_mem (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [bphq_pkg::PIN_W-1:0]       rd_addr,
	output logic [bphq_pkg::STAMP_W-1:0]     rd_data,
	input  bphq_pkg::ts_wr_t                 wr
);

	logic [bphq_pkg::STAMP_W-1:0] mem [bphq_pkg::PINS];
	logic [bphq_pkg::STAMP_W-1:0] rd_q;

	// Press timestamps: one write port, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> design/bphq_eval.sv
module bphq_eval (
	input  bphq_pkg::item_t                item,
	input  bphq_pkg::pin_state_t           st,
	input  logic [bphq_pkg::STAMP_W-1:0]   stamp,
	output bphq_pkg::st_wr_t               st_wr,
	output bphq_pkg::ts_wr_t               ts_wr,
	output bphq_pkg::result_t              res
);

	logic                         pressed;
	logic                         held;
	logic [bphq_pkg::STAMP_W-1:0] elapsed;

	assign pressed = item.level ^ item.active_low;
	assign elapsed = item.now_ms - stamp;
	assign held    = elapsed > {{(bphq_pkg::STAMP_W - bphq_pkg::HOLD_W){1'b0}}, item.hold_time};

	// Decide next pin state, timestamp update and the command produced
	always_comb begin
		st_wr.en      = 1'b0;
		st_wr.addr    = item.pin;
		st_wr.data    = bphq_pkg::ST_IDLE;
		ts_wr.en      = 1'b0;
		ts_wr.addr    = item.pin;
		ts_wr.data    = item.now_ms;
		res           = '0;
		unique case (item.kind)
			bphq_pkg::KIND_EDGE: begin
				if (pressed && st == bphq_pkg::ST_IDLE) begin
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_SET;
					res.result_value = item.value;
					res.changed      = 1'b1;
					res.write_enable = 1'b1;
					res.write_slot   = item.slot;
				end else if (!pressed) begin
					st_wr.en   = 1'b1;
					st_wr.data = bphq_pkg::ST_IDLE;
				end
			end
			bphq_pkg::KIND_FILTERED: begin
				if (pressed && st == bphq_pkg::ST_IDLE) begin
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_SET;
					res.result_value = item.value;
					res.changed      = 1'b1;
				end else if (pressed && st == bphq_pkg::ST_SET) begin
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_ACTIVE;
					res.result_value = item.value;
					res.changed      = 1'b1;
					res.write_enable = 1'b1;
					res.write_slot   = item.slot;
				end else if (!pressed && st == bphq_pkg::ST_ACTIVE) begin
					st_wr.en   = 1'b1;
					st_wr.data = bphq_pkg::ST_RELEASED;
				end else if (!pressed && (st == bphq_pkg::ST_RELEASED ||
						st == bphq_pkg::ST_SET)) begin
					st_wr.en   = 1'b1;
					st_wr.data = bphq_pkg::ST_IDLE;
				end
			end
			bphq_pkg::KIND_TWO_STATE: begin
				if (pressed && (st == bphq_pkg::ST_IDLE || st == bphq_pkg::ST_TS_OFF)) begin
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_TS_ON;
					res.result_value = item.value;
					res.changed      = 1'b1;
					res.write_enable = 1'b1;
					res.write_slot   = item.slot;
				end else if (!pressed && (st == bphq_pkg::ST_IDLE ||
						st == bphq_pkg::ST_TS_ON)) begin
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_TS_OFF;
					res.result_value = item.value_alt;
					res.changed      = 1'b1;
					res.write_enable = 1'b1;
					res.write_slot   = item.slot;
				end
			end
			bphq_pkg::KIND_PRESS_HOLD, bphq_pkg::KIND_REPEAT_HOLD: begin
				if (pressed && st == bphq_pkg::ST_IDLE) begin
					ts_wr.en   = 1'b1;
					st_wr.en   = 1'b1;
					st_wr.data = bphq_pkg::ST_SET;
				end else if (pressed && held && (st == bphq_pkg::ST_SET ||
						(item.kind == bphq_pkg::KIND_REPEAT_HOLD &&
						st == bphq_pkg::ST_ACTIVE))) begin
					// Repeat mode restarts the hold interval on each repeat
					ts_wr.en         = (item.kind == bphq_pkg::KIND_REPEAT_HOLD);
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_ACTIVE;
					res.result_value = item.value_alt;
					res.changed      = 1'b1;
					res.write_enable = 1'b1;
					res.write_slot   = (item.kind == bphq_pkg::KIND_PRESS_HOLD) ?
						item.slot_alt : item.slot;
				end else if (!pressed && st == bphq_pkg::ST_SET) begin
					st_wr.en         = 1'b1;
					st_wr.data       = bphq_pkg::ST_IDLE;
					res.result_value = item.value;
					res.changed      = 1'b1;
					res.write_enable = 1'b1;
					res.write_slot   = item.slot;
				end else if (!pressed && st == bphq_pkg::ST_ACTIVE) begin
					st_wr.en   = 1'b1;
					st_wr.data = bphq_pkg::ST_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/button_press_hold_qualifier_core.sv
// Stage 1 registers the accepted item and memory reads; out_q registers its result.
// Throughput: one transaction per cycle unless stalled; each pin sample is one read
// of the state and timestamp memories then one write back, same-pin writes forwarded.
// Reset: arst_n clears the pipeline, the output valid and the per-pin valid bits,
// so every pin reads as idle at once; no clearing pass, timestamps are not reset.
module button_press_hold_qualifier_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [4:0] pin, [5] level, [6] active_low, [14:7] value, [22:15] value_alt,
	// [30:23] slot, [38:31] slot_alt, [54:39] hold_time, [86:55] now_ms, [87] unused
	input  logic [87:0] s_axis_tdata,
	// [2:0] kind
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] result_value, [8] changed, [9] write_enable, [17:10] write_slot,
	// [23:18] zero
	output logic [23:0] m_axis_tdata
);

	bphq_pkg::item_t              item_in;
	bphq_pkg::item_t              item_s1;
	logic                         s1_valid_q;
	logic                         s1_adv;
	logic                         accept;
	bphq_pkg::pin_state_t         st_rd;
	logic [bphq_pkg::STAMP_W-1:0] ts_rd;
	bphq_pkg::pin_state_t         st_cur;
	logic [bphq_pkg::STAMP_W-1:0] ts_cur;
	bphq_pkg::st_wr_t             st_wr;
	bphq_pkg::ts_wr_t             ts_wr;
	bphq_pkg::st_wr_t             st_wr_g;
	bphq_pkg::ts_wr_t             ts_wr_g;
	bphq_pkg::result_t            res;
	logic                         byp_st_q;
	bphq_pkg::pin_state_t         byp_st_data_q;
	logic                         byp_ts_q;
	logic [bphq_pkg::STAMP_W-1:0] byp_ts_data_q;
	logic                         out_valid_q;
	bphq_pkg::result_t            out_q;

	// Unpack the input transaction
	assign item_in.kind       = s_axis_tuser;
	assign item_in.pin        = s_axis_tdata[4:0];
	assign item_in.level      = s_axis_tdata[5];
	assign item_in.active_low = s_axis_tdata[6];
	assign item_in.value      = s_axis_tdata[14:7];
	assign item_in.value_alt  = s_axis_tdata[22:15];
	assign item_in.slot       = s_axis_tdata[30:23];
	assign item_in.slot_alt   = s_axis_tdata[38:31];
	assign item_in.hold_time  = s_axis_tdata[54:39];
	assign item_in.now_ms     = s_axis_tdata[86:55];

	// Handshake: stage 1 moves on when the output register is free or draining
	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	bphq_state_mem u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (item_in.pin),
		.rd_data (st_rd),
		.wr      (st_wr_g)
	);

	bphq_stamp_mem u_stamp_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (item_in.pin),
		.rd_data (ts_rd),
		.wr      (ts_wr_g)
	);

	// Take forwarded data when the previous item wrote this pin on the read edge
	assign st_cur = byp_st_q ? byp_st_data_q : st_rd;
	assign ts_cur = byp_ts_q ? byp_ts_data_q : ts_rd;

	bphq_eval u_eval (
		.item  (item_s1),
		.st    (st_cur),
		.stamp (ts_cur),
		.st_wr (st_wr),
		.ts_wr (ts_wr),
		.res   (res)
	);

	// Commit write-back only when the item leaves stage 1
	always_comb begin
		st_wr_g    = st_wr;
		st_wr_g.en = st_wr.en && s1_adv;
		ts_wr_g    = ts_wr;
		ts_wr_g.en = ts_wr.en && s1_adv;
	end

	// Stage 1 item payload and forwarding data
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1       <= item_in;
			byp_st_data_q <= st_wr.data;
			byp_ts_data_q <= ts_wr.data;
		end
		if (s1_adv) begin
			out_q <= res;
		end
	end

	// Stage 1 control, forwarding flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			byp_st_q    <= 1'b0;
			byp_ts_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				byp_st_q   <= st_wr_g.en && (st_wr.addr == item_in.pin);
				byp_ts_q   <= ts_wr_g.en && (ts_wr.addr == item_in.pin);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
				byp_st_q   <= 1'b0;
				byp_ts_q   <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.write_slot, out_q.write_enable, out_q.changed,
		out_q.result_value};

	a_byp_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(byp_st_q || byp_ts_q) |-> s1_valid_q)
		else $error("forwarding flag set with stage 1 empty");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while pipeline is stalled");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.changed) |->
		(out_q.result_value == '0 && !out_q.write_enable && out_q.write_slot == '0))
		else $error("unchanged result carries a command");

	a_write_implies_changed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.write_enable) |-> out_q.changed)
		else $error("write strobe without a produced command");

endmodule
